// File: rtl/frp_pkg.sv
// ----------------------------------------------------------------------------
// frp_pkg
// Shared types and constants of the framed packet receiver: request and
// result payloads, frame status codes, frame marker bytes.
// ----------------------------------------------------------------------------
package frp_pkg;

  typedef logic [1:0] frp_status_t;

  localparam frp_status_t ST_NONE   = 2'd0;
  localparam frp_status_t ST_GOOD   = 2'd1;
  localparam frp_status_t ST_BADSUM = 2'd2;
  localparam frp_status_t ST_MARKER = 2'd3;

  localparam logic       FUNC_RX   = 1'b0;
  localparam logic       FUNC_READ = 1'b1;

  localparam logic [7:0] CH_S     = 8'h53;  // 'S'
  localparam logic [7:0] CH_P     = 8'h50;  // 'P'
  localparam logic [7:0] CH_D     = 8'h44;  // 'D'
  localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
  localparam logic [7:0] CH_E     = 8'h45;  // 'E'

  localparam int unsigned POS_W = 17;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
    logic       release_req;
  } frp_item_t;

  typedef struct packed {
    frp_status_t frame_status;
    logic [15:0] frame_length;
    logic        truncated;
    logic        bank;
    logic        frame_ready;
    logic [7:0]  read_data;
  } frp_result_t;

  // Per-request view of the state after the request, minus the payload byte
  typedef struct packed {
    frp_status_t frame_status;
    logic [15:0] frame_length;
    logic        truncated;
    logic        bank;
    logic        frame_ready;
    logic        rd_hit;
  } frp_info_t;

endpackage

// File: rtl/frp_ram.sv
// ----------------------------------------------------------------------------
// frp_ram
// Generic single-clock RAM: one write port, one read port, registered read
// that holds its value while no read is issued.
// ----------------------------------------------------------------------------
module frp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/frp_deframer.sv
// ----------------------------------------------------------------------------
// frp_deframer
// Frame parser and bank bookkeeping. Walks the byte position through the
// frame, checks markers and the additive checksum, writes payload bytes into
// the current bank and issues payload reads against the last good bank.
// ----------------------------------------------------------------------------
module frp_deframer #(
  parameter int BUF_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           take,
  input  frp_pkg::frp_item_t             item,
  output logic                           mem_we,
  output logic [$clog2(BUF_DEPTH):0]     mem_waddr,
  output logic [7:0]                     mem_wdata,
  output logic                           mem_re,
  output logic [$clog2(BUF_DEPTH):0]     mem_raddr,
  output frp_pkg::frp_info_t             info
);
  import frp_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int IW = (AW > 8) ? AW : 8;

  logic [POS_W-1:0] position, position_next;
  logic [15:0]      length_reg, length_reg_next;
  logic [7:0]       sum_reg, sum_reg_next;
  logic             write_bank, write_bank_next;
  logic             ready_flag, ready_flag_next;
  logic [15:0]      bank_length [2];
  logic [15:0]      bank_length_next [2];

  logic [POS_W-1:0] pay_end;
  logic [POS_W-1:0] pay_idx;
  logic [7:0]       b;
  logic             adv;
  logic             fail;
  frp_status_t      status;
  logic [15:0]      len_next;
  logic [15:0]      len_cur;
  logic [IW-1:0]    ridx;

  assign b       = item.rx_byte;
  assign pay_end = POS_W'(6) + POS_W'(length_reg);
  assign pay_idx = position - POS_W'(6);

  always_comb begin
    position_next       = position;
    length_reg_next     = length_reg;
    sum_reg_next        = sum_reg;
    write_bank_next     = write_bank;
    ready_flag_next     = ready_flag;
    bank_length_next[0] = bank_length[0];
    bank_length_next[1] = bank_length[1];
    status              = ST_NONE;
    adv                 = 1'b0;
    fail                = 1'b0;
    mem_we              = 1'b0;

    if (take && item.func == FUNC_RX) begin
      priority if (position == POS_W'(0)) begin
        adv = (b == CH_S);
      end else if (position == POS_W'(1)) begin
        adv  = (b == CH_P);
        fail = (b != CH_P);
      end else if (position == POS_W'(2)) begin
        length_reg_next = {b, 8'h00};
        adv             = 1'b1;
      end else if (position == POS_W'(3)) begin
        length_reg_next = {length_reg[15:8], b};
        adv             = 1'b1;
      end else if (position == POS_W'(4)) begin
        adv  = (b == CH_D);
        fail = (b != CH_D);
      end else if (position == POS_W'(5)) begin
        adv  = (b == CH_COLON);
        fail = (b != CH_COLON);
      end else if (position < pay_end) begin
        // drop payload bytes past the bank depth, but keep summing them
        mem_we = (pay_idx < POS_W'(BUF_DEPTH));
        adv    = 1'b1;
      end else if (position == pay_end) begin
        adv  = (b == CH_E);
        fail = (b != CH_E);
      end else if (position == pay_end + POS_W'(1)) begin
        adv  = (b == CH_D);
        fail = (b != CH_D);
      end else begin
        if (b == sum_reg) begin
          bank_length_next[write_bank] = length_reg;
          write_bank_next              = ~write_bank;
          ready_flag_next              = 1'b1;
          status                       = ST_GOOD;
        end else begin
          status = ST_BADSUM;
        end
        position_next = '0;
        sum_reg_next  = '0;
      end

      if (adv) begin
        position_next = position + POS_W'(1);
        sum_reg_next  = sum_reg + b;
      end
      if (fail) begin
        position_next = '0;
        sum_reg_next  = '0;
        status        = ST_MARKER;
      end
    end else if (take && item.release_req) begin
      ready_flag_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position       <= '0;
      length_reg     <= '0;
      sum_reg        <= '0;
      write_bank     <= 1'b0;
      ready_flag     <= 1'b0;
      bank_length[0] <= '0;
      bank_length[1] <= '0;
    end else if (take) begin
      position       <= position_next;
      length_reg     <= length_reg_next;
      sum_reg        <= sum_reg_next;
      write_bank     <= write_bank_next;
      ready_flag     <= ready_flag_next;
      bank_length[0] <= bank_length_next[0];
      bank_length[1] <= bank_length_next[1];
    end
  end

  assign mem_waddr = {write_bank, pay_idx[AW-1:0]};
  assign mem_wdata = b;

  // Reads target the bank not being written; its last write lies at least
  // three requests back, so the read never meets a pending write.
  assign ridx      = IW'(item.read_index);
  assign len_cur   = bank_length[~write_bank];
  assign mem_re    = take && (item.func == FUNC_READ);
  assign mem_raddr = {~write_bank, ridx[AW-1:0]};

  assign len_next = bank_length_next[~write_bank_next];

  always_comb begin
    info.frame_status = status;
    info.frame_length = len_next;
    info.truncated    = (POS_W'(len_next) > POS_W'(BUF_DEPTH));
    info.bank         = ~write_bank_next;
    info.frame_ready  = ready_flag_next;
    info.rd_hit       = (item.func == FUNC_READ)
                        && (POS_W'(item.read_index) < POS_W'(len_cur))
                        && (POS_W'(item.read_index) < POS_W'(BUF_DEPTH));
  end

endmodule

// File: rtl/frp_outq.sv
// ----------------------------------------------------------------------------
// frp_outq
// Two-deep result path: a read-wait stage that lines up with the RAM's
// registered read, then the output register that holds a stalled result.
// ----------------------------------------------------------------------------
module frp_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  frp_pkg::frp_info_t   info,
  input  logic [7:0]           mem_rdata,
  input  logic                 result_stall,
  output logic                 busy,
  output logic                 result_valid,
  output frp_pkg::frp_result_t result
);
  import frp_pkg::*;

  logic      s1_valid;
  frp_info_t s1_info;
  logic      s1_adv;

  assign s1_adv = !result_valid || !result_stall;
  assign busy   = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        result_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_info <= info;
    end
    if (s1_adv && s1_valid) begin
      result.frame_status <= s1_info.frame_status;
      result.frame_length <= s1_info.frame_length;
      result.truncated    <= s1_info.truncated;
      result.bank         <= s1_info.bank;
      result.frame_ready  <= s1_info.frame_ready;
      result.read_data    <= s1_info.rd_hit ? mem_rdata : 8'h00;
    end
  end

endmodule

// File: rtl/framed_packet_receiver_top.sv
// ----------------------------------------------------------------------------
// framed_packet_receiver_top
// Byte-wise frame receiver with ping-pong payload banks and readback.
// ----------------------------------------------------------------------------
// One request per clock while item_stall is low; each taken request gives
// exactly one result. A request either feeds one link byte of a frame 'S' 'P'
// LEN_HI LEN_LO 'D' ':' payload 'E' 'D' CHK into the parser, or reads one
// payload byte of the last good frame. Payload lives in a single RAM of two
// banks of 2**$clog2(BUF_DEPTH) bytes with a registered read; a result passes
// the read-wait stage and then the output register. Parser state sits in
// registers updated every taken request, so back-to-back requests need no
// interlock. Results leave through an output register; item_stall rises only
// when both the read-wait stage and the output register are full and
// result_stall is high.
module framed_packet_receiver_top #(
  parameter int BUF_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  frp_pkg::frp_item_t   item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output frp_pkg::frp_result_t result
);
  import frp_pkg::*;

  localparam int MAW = $clog2(BUF_DEPTH) + 1;

  logic           take;
  logic           busy;
  logic           mem_we;
  logic [MAW-1:0] mem_waddr;
  logic [7:0]     mem_wdata;
  logic           mem_re;
  logic [MAW-1:0] mem_raddr;
  logic [7:0]     mem_rdata;
  frp_info_t      info;

  assign item_stall = busy;
  assign take       = item_valid && !busy;

  frp_deframer #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_deframer (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .item     (item),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .info     (info)
  );

  frp_ram #(
    .WIDTH(8),
    .DEPTH(1 << MAW)
  ) u_payload_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  frp_outq u_outq (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .info        (info),
    .mem_rdata   (mem_rdata),
    .result_stall(result_stall),
    .busy        (busy),
    .result_valid(result_valid),
    .result      (result)
  );

endmodule

// File: rtl/frp_checker.sv
// ----------------------------------------------------------------------------
// frp_checker
// Port-level checks of the framed packet receiver, bound to the top level.
// ----------------------------------------------------------------------------
module frp_checker #(
  parameter int BUF_DEPTH = 256
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 result_valid,
  input logic                 result_stall,
  input frp_pkg::frp_result_t result
);
  import frp_pkg::*;

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // a committed frame always leaves the ready flag set
  a_good_ready: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.frame_status == ST_GOOD |-> result.frame_ready)
    else $error("good frame without ready flag");

  // link bytes that end or abort a frame never carry read data
  a_rx_no_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.frame_status != ST_NONE |-> result.read_data == 8'h00)
    else $error("receive result with read data");

  a_trunc: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      result.truncated == (32'(result.frame_length) > 32'(BUF_DEPTH)))
    else $error("truncated flag disagrees with length");

endmodule

bind framed_packet_receiver_top frp_checker #(
  .BUF_DEPTH(BUF_DEPTH)
) u_frp_checker (
  .clk         (clk),
  .rst         (rst),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result      (result)
);
